### rtl/swds_pkg.sv
// Shared types, constants and the opcode lookup for the shader word decode scan block.
`timescale 1ns / 1ps

package swds_pkg;

   localparam int MAX_PROGRAM_WORDS = 65536;

   localparam int LEN_W = 17;
   localparam int POS_W = $clog2(MAX_PROGRAM_WORDS + 1);
   localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int TEX_SLOTS = 256;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_CODES_ON = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROGRAM_LENGTH = 1'd1;

   localparam logic [4:0] OP_MOV = 5'd0;
   localparam logic [4:0] OP_SEL = 5'd1;
   localparam logic [4:0] OP_FADD = 5'd2;
   localparam logic [4:0] OP_FSUB = 5'd3;
   localparam logic [4:0] OP_FMUL = 5'd4;
   localparam logic [4:0] OP_FFMA = 5'd5;
   localparam logic [4:0] OP_FMNMX = 5'd6;
   localparam logic [4:0] OP_FCMP = 5'd7;
   localparam logic [4:0] OP_IADD = 5'd8;
   localparam logic [4:0] OP_ISUB = 5'd9;
   localparam logic [4:0] OP_IMUL = 5'd10;
   localparam logic [4:0] OP_IADD3 = 5'd11;
   localparam logic [4:0] OP_ISCADD = 5'd12;
   localparam logic [4:0] OP_LOP = 5'd13;
   localparam logic [4:0] OP_SHL = 5'd14;
   localparam logic [4:0] OP_SHR = 5'd15;
   localparam logic [4:0] OP_LDC = 5'd16;
   localparam logic [4:0] OP_TEX = 5'd17;
   localparam logic [4:0] OP_LDATTR = 5'd18;
   localparam logic [4:0] OP_STATTR = 5'd19;
   localparam logic [4:0] OP_BRA = 5'd20;
   localparam logic [4:0] OP_EXIT = 5'd21;
   localparam logic [4:0] OP_KIL = 5'd22;
   localparam logic [4:0] OP_SYNC = 5'd23;
   localparam logic [4:0] OP_S2R = 5'd24;
   localparam logic [4:0] OP_UNKNOWN = 5'd25;

   localparam logic [11:0] MAJ_MOV = 12'h5C0;
   localparam logic [11:0] MAJ_SEL = 12'h5C1;
   localparam logic [11:0] MAJ_FADD = 12'h580;
   localparam logic [11:0] MAJ_FSUB = 12'h581;
   localparam logic [11:0] MAJ_FMUL = 12'h582;
   localparam logic [11:0] MAJ_FFMA = 12'h583;
   localparam logic [11:0] MAJ_FMNMX = 12'h584;
   localparam logic [11:0] MAJ_FCMP = 12'h585;
   localparam logic [11:0] MAJ_IADD = 12'h5A0;
   localparam logic [11:0] MAJ_ISUB = 12'h5A1;
   localparam logic [11:0] MAJ_IMUL = 12'h5A2;
   localparam logic [11:0] MAJ_IADD3 = 12'h5A3;
   localparam logic [11:0] MAJ_ISCADD = 12'h5A4;
   localparam logic [11:0] MAJ_LOP = 12'h560;
   localparam logic [11:0] MAJ_SHL = 12'h561;
   localparam logic [11:0] MAJ_SHR = 12'h562;
   localparam logic [11:0] MAJ_LDC = 12'h530;
   localparam logic [11:0] MAJ_TEX = 12'h550;
   localparam logic [11:0] MAJ_LDATTR = 12'h5B0;
   localparam logic [11:0] MAJ_STATTR = 12'h5B1;
   localparam logic [11:0] MAJ_BRA = 12'h5D0;
   localparam logic [11:0] MAJ_EXIT = 12'h5D1;
   localparam logic [11:0] MAJ_KIL = 12'h5D2;
   localparam logic [11:0] MAJ_SYNC = 12'h5D3;
   localparam logic [11:0] MAJ_S2R = 12'h5F0;

   localparam logic [7:0] REG_NONE = 8'd255;

   typedef struct packed {
      logic [63:0] code_word;
      logic        program_start;
   } req_type;

   typedef struct packed {
      logic [18:0] byte_address;
      logic [4:0]  op_kind;
      logic [2:0]  guard_pred;
      logic        guard_invert;
      logic [1:0]  source_count;
      logic [31:0] reg_fields;
      logic [31:0] aux_value;
      logic [7:0]  highest_register;
      logic [31:0] bank_mask;
      logic        texture_new;
      logic        discard_seen;
      logic        program_end;
   } rsp_type;

   // one classified word handed from front to back
   typedef struct packed {
      logic [63:0]      code_word;
      logic [POS_W-1:0] position;
      logic [4:0]       kind;
      logic             clear;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } qport_type;

   function automatic logic [4:0] op_kind_of(input logic [11:0] major);
      logic [4:0] kind;
      case (major)
         MAJ_MOV: kind = OP_MOV;
         MAJ_SEL: kind = OP_SEL;
         MAJ_FADD: kind = OP_FADD;
         MAJ_FSUB: kind = OP_FSUB;
         MAJ_FMUL: kind = OP_FMUL;
         MAJ_FFMA: kind = OP_FFMA;
         MAJ_FMNMX: kind = OP_FMNMX;
         MAJ_FCMP: kind = OP_FCMP;
         MAJ_IADD: kind = OP_IADD;
         MAJ_ISUB: kind = OP_ISUB;
         MAJ_IMUL: kind = OP_IMUL;
         MAJ_IADD3: kind = OP_IADD3;
         MAJ_ISCADD: kind = OP_ISCADD;
         MAJ_LOP: kind = OP_LOP;
         MAJ_SHL: kind = OP_SHL;
         MAJ_SHR: kind = OP_SHR;
         MAJ_LDC: kind = OP_LDC;
         MAJ_TEX: kind = OP_TEX;
         MAJ_LDATTR: kind = OP_LDATTR;
         MAJ_STATTR: kind = OP_STATTR;
         MAJ_BRA: kind = OP_BRA;
         MAJ_EXIT: kind = OP_EXIT;
         MAJ_KIL: kind = OP_KIL;
         MAJ_SYNC: kind = OP_SYNC;
         MAJ_S2R: kind = OP_S2R;
         default: kind = OP_UNKNOWN;
      endcase
      return kind;
   endfunction

endpackage

### rtl/swds_front.sv
// Front end: config registers, word position, control-word skip, exit gating, classification.
`timescale 1ns / 1ps

module swds_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [swds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [swds_pkg::LEN_W-1:0]         csr_wdata,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  swds_pkg::req_type                  req_data,
   output swds_pkg::qport_type                push
);

   logic                         ccode_ff;
   logic [swds_pkg::LEN_W-1:0]   len_ff;
   logic [swds_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                         exit_ff, exit_in;
   logic                         clr_ff, clr_in;

   logic                         accept, start, exit_cur, live, ctrl, emit, bundle_fits;
   logic [swds_pkg::POS_W-1:0]   pos_cur;
   logic [swds_pkg::CMP_W-1:0]   len_ext, len_eff, max_ext, pos_ext;
   logic [4:0]                   kind;

   always_comb begin
      accept = req_valid && !req_stall;
      start = req_data.program_start;
      pos_cur = start ? '0 : pos_ff;
      exit_cur = start ? 1'b0 : exit_ff;
      len_ext = swds_pkg::CMP_W'(len_ff);
      max_ext = swds_pkg::CMP_W'(swds_pkg::MAX_PROGRAM_WORDS);
      len_eff = (len_ext > max_ext) ? max_ext : len_ext;
      pos_ext = swds_pkg::CMP_W'(pos_cur);
      live = !exit_cur && (pos_ext < len_eff);
      // control word only when the whole 4-word bundle lies inside the program
      bundle_fits = ({1'b0, pos_ext} + (swds_pkg::CMP_W + 1)'(4)) <= {1'b0, len_eff};
      ctrl = ccode_ff && (pos_cur[1:0] == 2'b00) && bundle_fits;
      emit = accept && live && !ctrl;
      kind = swds_pkg::op_kind_of(req_data.code_word[63:52]);

      pos_in = pos_ff;
      exit_in = exit_ff;
      clr_in = clr_ff;
      if (accept) begin
         pos_in = live ? (pos_cur + swds_pkg::POS_W'(1)) : pos_cur;
         exit_in = exit_cur || (emit && (kind == swds_pkg::OP_EXIT));
         // a start word that yields nothing still owes the back a tracker clear
         clr_in = !emit && (start || clr_ff);
      end

      push.valid = emit;
      push.entry.code_word = req_data.code_word;
      push.entry.position = pos_cur;
      push.entry.kind = kind;
      push.entry.clear = start || clr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ccode_ff <= 1'b0;
         len_ff <= '0;
         pos_ff <= '0;
         exit_ff <= 1'b0;
         clr_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               swds_pkg::CSR_CONTROL_CODES_ON: ccode_ff <= csr_wdata[0];
               swds_pkg::CSR_PROGRAM_LENGTH: len_ff <= csr_wdata;
               default: ;
            endcase
         end
         pos_ff <= pos_in;
         exit_ff <= exit_in;
         clr_ff <= clr_in;
      end
   end

endmodule

### rtl/swds_queue.sv
// Short flip-flop queue of classified words between front and back.
`timescale 1ns / 1ps

module swds_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  swds_pkg::qport_type  push,
   input  logic                 pop,
   output swds_pkg::qport_type  head,
   output logic                 full
);

   swds_pkg::entry_type            slot_ff [swds_pkg::QUEUE_DEPTH];
   logic [swds_pkg::QPTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [swds_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;
   logic                           do_pop;

   function automatic logic [swds_pkg::QPTR_W-1:0] next_ptr(
      input logic [swds_pkg::QPTR_W-1:0] ptr);
      return (ptr == swds_pkg::QPTR_W'(swds_pkg::QUEUE_DEPTH - 1)) ?
             '0 : ptr + swds_pkg::QPTR_W'(1);
   endfunction

   always_comb begin
      full = (cnt_ff == swds_pkg::QCNT_W'(swds_pkg::QUEUE_DEPTH));
      head.valid = (cnt_ff != '0);
      head.entry = slot_ff[rd_ff];
      do_pop = pop && head.valid;
      wr_in = push.valid ? next_ptr(wr_ff) : wr_ff;
      rd_in = do_pop ? next_ptr(rd_ff) : rd_ff;
      cnt_in = cnt_ff;
      if (push.valid && !do_pop) begin
         cnt_in = cnt_ff + swds_pkg::QCNT_W'(1);
      end else if (!push.valid && do_pop) begin
         cnt_in = cnt_ff - swds_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full && !pop))
      else $error("queue written while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= swds_pkg::QCNT_W'(swds_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");
`endif

endmodule

### rtl/swds_back.sv
// Back end: field decode, usage trackers and the registered result word.
`timescale 1ns / 1ps

module swds_back (
   input  logic                 clock,
   input  logic                 reset,
   input  swds_pkg::qport_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output swds_pkg::rsp_type    rsp_data
);

   logic                               rsp_valid_ff, rsp_valid_in;
   swds_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   logic [7:0]                         maxreg_ff, maxreg_in;
   logic [31:0]                        banks_ff, banks_in;
   logic [swds_pkg::TEX_SLOTS-1:0]     tex_ff, tex_in;
   logic                               kill_ff, kill_in;

   logic [63:0]  w;
   logic [4:0]   kind;
   logic [7:0]   rd, ra, rb, rc;
   logic [31:0]  addr, rel, aux;
   logic [1:0]   nsrc;
   logic         use_d, use_a, use_b, use_c, tex_new;
   logic [7:0]   cand [4];
   logic [3:0]   cand_use;
   logic [4:0]   bank;

   always_comb begin
      w = head.entry.code_word;
      kind = head.entry.kind;
      rd = w[7:0];
      ra = w[15:8];
      rb = w[27:20];
      rc = w[39:32];
      addr = 32'({head.entry.position, 3'b000});
      bank = w[24:20];
      rel = {{8{w[43]}}, w[43:20]};

      maxreg_in = head.entry.clear ? '0 : maxreg_ff;
      banks_in = head.entry.clear ? '0 : banks_ff;
      tex_in = head.entry.clear ? '0 : tex_ff;
      kill_in = head.entry.clear ? 1'b0 : kill_ff;

      nsrc = 2'd0;
      aux = '0;
      use_d = 1'b1;
      use_a = 1'b0;
      use_b = 1'b0;
      use_c = 1'b0;
      tex_new = 1'b0;

      case (kind)
         swds_pkg::OP_MOV: begin
            nsrc = 2'd1;
            use_a = 1'b1;
         end
         swds_pkg::OP_FFMA, swds_pkg::OP_IADD3: begin
            nsrc = 2'd3;
            use_a = 1'b1;
            use_b = 1'b1;
            use_c = 1'b1;
         end
         swds_pkg::OP_ISCADD: begin
            nsrc = 2'd3;
            use_a = 1'b1;
            use_b = 1'b1;
            aux = 32'(w[44:40]);
         end
         swds_pkg::OP_TEX: begin
            nsrc = 2'd3;
            use_a = 1'b1;
            use_b = 1'b1;
            aux = 32'(rc);
            tex_new = !tex_in[rc];
            tex_in[rc] = 1'b1;
         end
         swds_pkg::OP_LDC: begin
            nsrc = 2'd1;
            aux = {11'd0, bank, w[43:28]};
            banks_in[bank] = 1'b1;
         end
         swds_pkg::OP_LDATTR, swds_pkg::OP_STATTR: begin
            nsrc = 2'd1;
            aux = {20'd0, w[29:20], w[31:30]};
            if (kind == swds_pkg::OP_STATTR) begin
               use_d = 1'b0;
               use_a = 1'b1;
            end
         end
         swds_pkg::OP_S2R: begin
            nsrc = 2'd1;
            aux = 32'(rb);
         end
         swds_pkg::OP_BRA: begin
            aux = addr + rel;
         end
         swds_pkg::OP_EXIT, swds_pkg::OP_SYNC, swds_pkg::OP_UNKNOWN: ;
         swds_pkg::OP_KIL: begin
            kill_in = 1'b1;
         end
         default: begin
            nsrc = 2'd2;
            use_a = 1'b1;
            use_b = 1'b1;
         end
      endcase

      // running max over the register slots this opcode names; 255 means none
      cand[0] = rd;
      cand[1] = ra;
      cand[2] = rb;
      cand[3] = rc;
      cand_use = {use_c, use_b, use_a, use_d};
      for (int i = 0; i < 4; i++) begin
         if (cand_use[i] && (cand[i] != swds_pkg::REG_NONE) && (cand[i] > maxreg_in)) begin
            maxreg_in = cand[i];
         end
      end

      rsp_data_in.byte_address = addr[18:0];
      rsp_data_in.op_kind = kind;
      rsp_data_in.guard_pred = w[18:16];
      rsp_data_in.guard_invert = w[19];
      rsp_data_in.source_count = nsrc;
      rsp_data_in.reg_fields = {use_c ? rc : 8'd0, use_b ? rb : 8'd0,
                                use_a ? ra : 8'd0, use_d ? rd : 8'd0};
      rsp_data_in.aux_value = aux;
      rsp_data_in.highest_register = maxreg_in;
      rsp_data_in.bank_mask = banks_in;
      rsp_data_in.texture_new = tex_new;
      rsp_data_in.discard_seen = kill_in;
      rsp_data_in.program_end = (kind == swds_pkg::OP_EXIT);

      pop = head.valid && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         maxreg_ff <= '0;
         banks_ff <= '0;
         tex_ff <= '0;
         kill_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            maxreg_ff <= maxreg_in;
            banks_ff <= banks_in;
            tex_ff <= tex_in;
            kill_ff <= kill_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTH
   a_maxreg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.highest_register != swds_pkg::REG_NONE))
      else $error("highest register reached 255");
   a_end_is_exit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.program_end) |->
      (rsp_data_ff.op_kind == swds_pkg::OP_EXIT))
      else $error("program end on a non-EXIT word");
   a_texnew_is_tex: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.texture_new) |->
      (rsp_data_ff.op_kind == swds_pkg::OP_TEX))
      else $error("texture first-use mark on a non-TEX word");
`endif

endmodule

### rtl/shader_word_decode_scan_core.sv
// Top level of the shader word decode scan block.
`timescale 1ns / 1ps

// Takes one 64-bit program word per cycle while req_stall is low and returns one
// decoded word per instruction; an accepted word passes through the queue and the
// registered result word before rsp_valid rises.
// The front tracks the word position, skips bundle control words and stops at
// EXIT; a two-entry queue decouples it from the back, which decodes the fields
// and updates the running trackers (highest register, bank mask, 256-entry
// texture mark bitmap, discard flag) as each word is popped, so the sustained
// rate is one word per cycle while the result side is not stalled. Skipped
// and ignored words produce no result. req_stall rises only while the queue is
// full. Write control_codes_on (index 0) and program_length_words (index 1)
// only while the block is idle.
module shader_word_decode_scan_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [swds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [swds_pkg::LEN_W-1:0]         csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  swds_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output swds_pkg::rsp_type                  rsp_data
);

   swds_pkg::qport_type push;
   swds_pkg::qport_type head;
   logic                pop;
   logic                q_full;

   assign req_stall = q_full;

   swds_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push)
   );

   swds_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   swds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the shader word decode scan block.
`timescale 1ns / 1ps

module testbench;

   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_LIMIT = 5000;
   localparam int TAIL_CYCLES = 8;
   localparam logic [11:0] MAJ_UNUSED = 12'hFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [swds_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [swds_pkg::LEN_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   swds_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   swds_pkg::rsp_type rsp_data;

   shader_word_decode_scan_core dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // scan state as the block should hold it
   bit          bundle_ctl;
   logic [16:0] prog_words;
   int          scan_pos;
   bit          scan_done;
   logic [7:0]  peak_reg;
   logic [31:0] bank_bits;
   bit          tex_seen [0:swds_pkg::TEX_SLOTS-1];
   bit          kill_hit;

   swds_pkg::rsp_type pending_decodes [$];

   int error_count = 0;
   int decodes_checked = 0;
   int words_sent = 0;
   int words_consumed = 0;
   int settings_used = 0;
   int burst_left = 0;
   bit sender_gaps = 1'b1;
   int hold_requests = 0;

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   function automatic void clear_scan();
      scan_pos = 0;
      scan_done = 1'b0;
      peak_reg = '0;
      bank_bits = '0;
      kill_hit = 1'b0;
      foreach (tex_seen[i])
         tex_seen[i] = 1'b0;
   endfunction

   function automatic logic [11:0] major_for(input logic [4:0] kind);
      case (kind)
         swds_pkg::OP_MOV: return swds_pkg::MAJ_MOV;
         swds_pkg::OP_SEL: return swds_pkg::MAJ_SEL;
         swds_pkg::OP_FADD: return swds_pkg::MAJ_FADD;
         swds_pkg::OP_FSUB: return swds_pkg::MAJ_FSUB;
         swds_pkg::OP_FMUL: return swds_pkg::MAJ_FMUL;
         swds_pkg::OP_FFMA: return swds_pkg::MAJ_FFMA;
         swds_pkg::OP_FMNMX: return swds_pkg::MAJ_FMNMX;
         swds_pkg::OP_FCMP: return swds_pkg::MAJ_FCMP;
         swds_pkg::OP_IADD: return swds_pkg::MAJ_IADD;
         swds_pkg::OP_ISUB: return swds_pkg::MAJ_ISUB;
         swds_pkg::OP_IMUL: return swds_pkg::MAJ_IMUL;
         swds_pkg::OP_IADD3: return swds_pkg::MAJ_IADD3;
         swds_pkg::OP_ISCADD: return swds_pkg::MAJ_ISCADD;
         swds_pkg::OP_LOP: return swds_pkg::MAJ_LOP;
         swds_pkg::OP_SHL: return swds_pkg::MAJ_SHL;
         swds_pkg::OP_SHR: return swds_pkg::MAJ_SHR;
         swds_pkg::OP_LDC: return swds_pkg::MAJ_LDC;
         swds_pkg::OP_TEX: return swds_pkg::MAJ_TEX;
         swds_pkg::OP_LDATTR: return swds_pkg::MAJ_LDATTR;
         swds_pkg::OP_STATTR: return swds_pkg::MAJ_STATTR;
         swds_pkg::OP_BRA: return swds_pkg::MAJ_BRA;
         swds_pkg::OP_EXIT: return swds_pkg::MAJ_EXIT;
         swds_pkg::OP_KIL: return swds_pkg::MAJ_KIL;
         swds_pkg::OP_SYNC: return swds_pkg::MAJ_SYNC;
         swds_pkg::OP_S2R: return swds_pkg::MAJ_S2R;
         default: return MAJ_UNUSED;
      endcase
   endfunction

   function automatic logic [4:0] kind_from_major(input logic [11:0] major);
      for (int k = 0; k < swds_pkg::OP_UNKNOWN; k++)
         if (major_for(k[4:0]) == major)
            return k[4:0];
      return swds_pkg::OP_UNKNOWN;
   endfunction

   function automatic void track_reg(input logic [7:0] r);
      if (r != swds_pkg::REG_NONE && r > peak_reg)
         peak_reg = r;
   endfunction

   // Returns 1 when the word yields a decode; consumed is set when the word
   // advanced the position (decoded or skipped as a bundle control word).
   function automatic bit decode_and_track(input swds_pkg::req_type item,
                                           output swds_pkg::rsp_type d,
                                           output bit consumed);
      logic [63:0] w;
      int lim, p;
      logic [4:0] kind;
      logic [7:0] rd, ra, rb, rc;
      logic [31:0] addr, rel, aux;
      logic [1:0] nsrc;
      bit keep_d, use_a, use_b, use_c, tex_new;
      w = item.code_word;
      d = '0;
      consumed = 1'b0;
      if (item.program_start)
         clear_scan();
      if (scan_done)
         return 1'b0;
      lim = (int'(prog_words) > swds_pkg::MAX_PROGRAM_WORDS) ?
            swds_pkg::MAX_PROGRAM_WORDS : int'(prog_words);
      p = scan_pos;
      if (p >= lim)
         return 1'b0;
      scan_pos = p + 1;
      consumed = 1'b1;
      if (bundle_ctl && (p % 4) == 0 && p + 4 <= lim)
         return 1'b0;

      addr = p * 8;
      kind = kind_from_major(w[63:52]);
      rd = w[7:0];
      ra = w[15:8];
      rb = w[27:20];
      rc = w[39:32];
      nsrc = 2'd0;
      aux = '0;
      tex_new = 1'b0;
      keep_d = 1'b1;
      use_a = 1'b0;
      use_b = 1'b0;
      use_c = 1'b0;

      case (kind)
         swds_pkg::OP_MOV: begin
            nsrc = 2'd1;
            use_a = 1'b1;
         end
         swds_pkg::OP_FFMA, swds_pkg::OP_IADD3: begin
            nsrc = 2'd3;
            use_a = 1'b1;
            use_b = 1'b1;
            use_c = 1'b1;
         end
         swds_pkg::OP_ISCADD: begin
            nsrc = 2'd3;
            use_a = 1'b1;
            use_b = 1'b1;
            aux = {27'd0, w[44:40]};
         end
         swds_pkg::OP_TEX: begin
            nsrc = 2'd3;
            use_a = 1'b1;
            use_b = 1'b1;
            aux = {24'd0, rc};
            if (!tex_seen[rc]) begin
               tex_new = 1'b1;
               tex_seen[rc] = 1'b1;
            end
         end
         swds_pkg::OP_LDC: begin
            nsrc = 2'd1;
            aux = {11'd0, w[24:20], w[43:28]};
            bank_bits[w[24:20]] = 1'b1;
         end
         swds_pkg::OP_LDATTR: begin
            nsrc = 2'd1;
            aux = {20'd0, w[29:20], w[31:30]};
         end
         swds_pkg::OP_STATTR: begin
            // stores have no destination register
            nsrc = 2'd1;
            aux = {20'd0, w[29:20], w[31:30]};
            keep_d = 1'b0;
            use_a = 1'b1;
         end
         swds_pkg::OP_S2R: begin
            nsrc = 2'd1;
            aux = {24'd0, rb};
         end
         swds_pkg::OP_BRA: begin
            rel = {{8{w[43]}}, w[43:20]};
            aux = addr + rel;
         end
         swds_pkg::OP_EXIT: scan_done = 1'b1;
         swds_pkg::OP_KIL: kill_hit = 1'b1;
         swds_pkg::OP_SYNC, swds_pkg::OP_UNKNOWN: ;
         default: begin
            nsrc = 2'd2;
            use_a = 1'b1;
            use_b = 1'b1;
         end
      endcase

      if (keep_d) begin
         d.reg_fields[7:0] = rd;
         track_reg(rd);
      end
      if (use_a) begin
         d.reg_fields[15:8] = ra;
         track_reg(ra);
      end
      if (use_b) begin
         d.reg_fields[23:16] = rb;
         track_reg(rb);
      end
      if (use_c) begin
         d.reg_fields[31:24] = rc;
         track_reg(rc);
      end

      d.byte_address = addr[18:0];
      d.op_kind = kind;
      d.guard_pred = w[18:16];
      d.guard_invert = w[19];
      d.source_count = nsrc;
      d.aux_value = aux;
      d.highest_register = peak_reg;
      d.bank_mask = bank_bits;
      d.texture_new = tex_new;
      d.discard_seen = kill_hit;
      d.program_end = (kind == swds_pkg::OP_EXIT);
      return 1'b1;
   endfunction

   function automatic string describe_diffs(input swds_pkg::rsp_type want,
                                            input swds_pkg::rsp_type got);
      string s;
      s = "";
      if (got.byte_address !== want.byte_address)
         s = {s, $sformatf(" byte_address exp %h got %h", want.byte_address, got.byte_address)};
      if (got.op_kind !== want.op_kind)
         s = {s, $sformatf(" op_kind exp %0d got %0d", want.op_kind, got.op_kind)};
      if (got.guard_pred !== want.guard_pred)
         s = {s, $sformatf(" guard_pred exp %0d got %0d", want.guard_pred, got.guard_pred)};
      if (got.guard_invert !== want.guard_invert)
         s = {s, $sformatf(" guard_invert exp %b got %b", want.guard_invert, got.guard_invert)};
      if (got.source_count !== want.source_count)
         s = {s, $sformatf(" source_count exp %0d got %0d", want.source_count,
                           got.source_count)};
      if (got.reg_fields !== want.reg_fields)
         s = {s, $sformatf(" reg_fields exp %h got %h", want.reg_fields, got.reg_fields)};
      if (got.aux_value !== want.aux_value)
         s = {s, $sformatf(" aux_value exp %h got %h", want.aux_value, got.aux_value)};
      if (got.highest_register !== want.highest_register)
         s = {s, $sformatf(" highest_register exp %0d got %0d", want.highest_register,
                           got.highest_register)};
      if (got.bank_mask !== want.bank_mask)
         s = {s, $sformatf(" bank_mask exp %h got %h", want.bank_mask, got.bank_mask)};
      if (got.texture_new !== want.texture_new)
         s = {s, $sformatf(" texture_new exp %b got %b", want.texture_new, got.texture_new)};
      if (got.discard_seen !== want.discard_seen)
         s = {s, $sformatf(" discard_seen exp %b got %b", want.discard_seen,
                           got.discard_seen)};
      if (got.program_end !== want.program_end)
         s = {s, $sformatf(" program_end exp %b got %b", want.program_end, got.program_end)};
      return s;
   endfunction

   // result side: compare every accepted word against the oldest prediction
   always @(posedge clock) begin : check_results
      swds_pkg::rsp_type want;
      string diffs;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_decodes.size() == 0) begin
            note_error($sformatf("unexpected decode at byte %h", rsp_data.byte_address));
         end else begin
            want = pending_decodes.pop_front();
            decodes_checked++;
            diffs = describe_diffs(want, rsp_data);
            if (diffs != "")
               note_error({$sformatf("decode mismatch at byte %h:", want.byte_address),
                           diffs});
         end
      end
   end

   // receiver stall pattern, with a long hold-off on request
   int hold_left = 0;
   int holds_served = 0;
   int mode_left = 0;
   int stall_mode = 0;
   int stall_tick = 0;

   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(16, 160);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((stall_tick % 5) < 2);
         endcase
      end
   end

   task automatic send_word(input logic [63:0] w, input bit start);
      swds_pkg::req_type item;
      swds_pkg::rsp_type d;
      bit consumed;
      int gap;
      item.code_word = w;
      item.program_start = start;
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      words_sent++;
      if (decode_and_track(item, d, consumed))
         pending_decodes.insert(pending_decodes.size(), d);
      if (consumed)
         words_consumed++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 23);
         if (sender_gaps) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // let all outstanding decodes drain, then wait out TAIL_CYCLES for skipped words
   task automatic settle_block();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_decodes.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_decodes.size() != 0) begin
         error_count += pending_decodes.size() - 1;
         note_error($sformatf("%0d expected decodes never arrived", pending_decodes.size()));
         pending_decodes.delete();
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input bit codes_on, input logic [16:0] length);
      logic [16:0] ctl_data;
      ctl_data = 17'($urandom());
      ctl_data[0] = codes_on;
      csr_we <= 1'b1;
      csr_index <= swds_pkg::CSR_CONTROL_CODES_ON;
      csr_wdata <= ctl_data;
      @(posedge clock);
      bundle_ctl = codes_on;
      csr_index <= swds_pkg::CSR_PROGRAM_LENGTH;
      csr_wdata <= length;
      @(posedge clock);
      prog_words = length;
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [63:0] random_instruction(input bit want_exit);
      logic [63:0] w;
      int pick;
      int k;
      w = {$urandom(), $urandom()};
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 23);
      if (k >= swds_pkg::OP_EXIT)
         k++;
      if (want_exit)
         w[63:52] = swds_pkg::MAJ_EXIT;
      else if (pick < 90)
         w[63:52] = major_for(k[4:0]);
      else if (pick < 92)
         w[63:52] = swds_pkg::MAJ_EXIT;
      // otherwise the random major stays, almost always an unknown opcode
      if ($urandom_range(0, 1)) begin
         // low register numbers so the running max climbs and textures repeat
         w[7:0] = w[7:0] & 8'h1F;
         w[15:8] = w[15:8] & 8'h1F;
         w[27:20] = w[27:20] & 8'h1F;
         w[39:32] = w[39:32] & 8'h1F;
      end
      return w;
   endfunction

   // random programs: start word, body, usually EXIT, sometimes trailing junk
   task automatic run_programs(input int target);
      int stop, n, i, extra;
      bit start;
      stop = words_sent + target;
      while (words_sent < stop) begin
         sender_gaps = ($urandom_range(0, 3) != 0);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
         for (i = 0; i < n; i++) begin
            start = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
            send_word(random_instruction(i == n - 1 && $urandom_range(0, 3) != 0), start);
         end
         if ($urandom_range(0, 2) == 0) begin
            extra = $urandom_range(1, 3);
            for (i = 0; i < extra; i++)
               send_word(random_instruction(1'b0), 1'b0);
         end
      end
   endtask

   task automatic test_each_opcode();
      logic [63:0] w;
      int k;
      settle_block();
      configure(1'b0, 17'h10000);
      sender_gaps = 1'b0;
      // all ones: every register byte is 255 and stays out of the max
      send_word({swds_pkg::MAJ_MOV, {52{1'b1}}}, 1'b1);
      send_word({swds_pkg::MAJ_SEL, 52'd0}, 1'b0);
      for (k = swds_pkg::OP_FADD; k <= swds_pkg::OP_STATTR; k++) begin
         w = {$urandom(), $urandom()};
         w[63:52] = major_for(k[4:0]);
         if (k == swds_pkg::OP_FADD)
            w[7:0] = 8'd254;
         if (k == swds_pkg::OP_LDC)
            w[24:20] = 5'h1F;
         send_word(w, 1'b0);
         if (k == swds_pkg::OP_TEX)
            send_word(w, 1'b0);
      end
      w = {$urandom(), $urandom()};
      w[63:52] = swds_pkg::MAJ_BRA;
      w[43:20] = 24'h800000;
      send_word(w, 1'b0);
      w[43:20] = 24'h7FFFFF;
      send_word(w, 1'b0);
      send_word({swds_pkg::MAJ_S2R, 32'($urandom()), 20'($urandom_range(0, 1048575))}, 1'b0);
      send_word({swds_pkg::MAJ_KIL, 32'($urandom()), 20'($urandom_range(0, 1048575))}, 1'b0);
      send_word({swds_pkg::MAJ_SYNC, 32'($urandom()), 20'($urandom_range(0, 1048575))}, 1'b0);
      send_word({MAJ_UNUSED, 32'($urandom()), 20'($urandom_range(0, 1048575))}, 1'b0);
      send_word({swds_pkg::MAJ_EXIT, 32'($urandom()), 20'($urandom_range(0, 1048575))}, 1'b0);
      // ignored: program already ended
      send_word({swds_pkg::MAJ_MOV, 32'($urandom()), 20'($urandom_range(0, 1048575))}, 1'b0);
   endtask

   task automatic test_plain_stream();
      settle_block();
      configure(1'b0, 17'h10000);
      run_programs(400);
   endtask

   task automatic test_bundled_stream();
      settle_block();
      configure(1'b1, 17'h10000);
      run_programs(400);
   endtask

   task automatic test_length_clamp();
      settle_block();
      configure(1'b1, 17'h1FFFF);
      run_programs(150);
   endtask

   // short programs: partial last bundle and words past the end
   task automatic test_short_programs();
      int lens [7] = '{1, 3, 4, 5, 8, 9, 13};
      int i;
      for (i = 0; i < 7; i++) begin
         settle_block();
         configure(1'b1, 17'(lens[i]));
         run_programs(40);
      end
      settle_block();
      configure(1'b0, 17'd7);
      run_programs(80);
   endtask

   task automatic test_zero_length();
      int i;
      settle_block();
      configure(1'($urandom_range(0, 1)), 17'd0);
      sender_gaps = 1'b1;
      for (i = 0; i < 24; i++)
         send_word(random_instruction(1'b0), $urandom_range(0, 2) == 0);
   endtask

   task automatic test_result_backpressure();
      int i;
      settle_block();
      configure(1'b0, 17'h10000);
      sender_gaps = 1'b0;
      hold_requests++;
      for (i = 0; i < 60; i++)
         send_word(random_instruction(i == 59), i == 0);
   endtask

   initial begin
      bundle_ctl = 1'b0;
      prog_words = '0;
      clear_scan();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_each_opcode();
      test_plain_stream();
      test_bundled_stream();
      test_length_clamp();
      test_short_programs();
      test_zero_length();
      test_result_backpressure();
      settle_block();
      $display("summary: %0d words offered, %0d consumed by the scan, %0d decodes checked",
               words_sent, words_consumed, decodes_checked);
      $display("summary: %0d register settings, %0d long result hold-offs, %0d errors",
               settings_used, holds_served, error_count);
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
